[hw/rtl/krt_pkg.sv]
// shared types, widths and codes of the keyed record table
package krt_pkg;

  localparam int CAPACITY_DEF = 8;

  localparam int OP_W    = 3;
  localparam int KEY_W   = 32;
  localparam int QTY_W   = 16;
  localparam int PRICE_W = 24;
  localparam int ST_W    = 3;
  localparam int CNT_W   = 4;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_QTY = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_PRICE = 3'd4;
  localparam logic [OP_W-1:0] OP_LIST = 3'd5;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_DUP      = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [ST_W-1:0] ST_INVALID  = 3'd5;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [QTY_W-1:0]        qty;
    logic [PRICE_W-1:0]      price;
  } rec_t;

endpackage

[hw/rtl/krt_if.sv]
// valid/ready channel interfaces for request and result items
interface krt_in_if;
  import krt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [KEY_W-1:0] item_key;
  logic [QTY_W-1:0]        quantity_in;
  logic [PRICE_W-1:0]      price_in;

  modport source (output valid, output operation, output item_key, output quantity_in,
                  output price_in, input ready);
  modport sink (input valid, input operation, input item_key, input quantity_in,
                input price_in, output ready);
endinterface

interface krt_out_if;
  import krt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [KEY_W-1:0] key_out;
  logic [QTY_W-1:0]        quantity_out;
  logic [PRICE_W-1:0]      price_out;
  logic [CNT_W-1:0]        entry_count;
  logic                    last;

  modport source (output valid, output status, output key_out, output quantity_out,
                  output price_out, output entry_count, output last, input ready);
  modport sink (input valid, input status, input key_out, input quantity_out,
                input price_out, input entry_count, input last, output ready);
endinterface

[hw/rtl/keyed_record_table.sv]
// keyed record table top level: sequencer plus record memory
// a rejected op, or any op but insert on an empty table, goes straight to the result; lookup
//   scans keys from slot 0; delete moves each later record down; new keys are added at the end
// list: records in slot order, one record per cycle as the output drains
// input ready again from the edge that loads the last result; output stalls hold the sequencer
// reset: synchronous active-low rst_n clears the record count, sequencer and output valid
module keyed_record_table #(
  parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  krt_in_if.sink    in_item,
  krt_out_if.source out_item
);
  import krt_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_raddr;
  rec_t          mem_wdata;
  rec_t          mem_rdata;

  krt_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_item  (out_item),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  krt_store #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[hw/rtl/krt_store.sv]
// record memory: one write port, one registered read port
module krt_store #(
  parameter int CAPACITY = krt_pkg::CAPACITY_DEF,
  parameter int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  krt_pkg::rec_t wdata,
  input  logic [IW-1:0] raddr,
  output krt_pkg::rec_t rdata
);
  import krt_pkg::*;

  rec_t mem [CAPACITY];
  rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/krt_ctrl.sv]
// sequencer with the shared key comparator, record count and output register
module krt_ctrl #(
  parameter int CAPACITY = krt_pkg::CAPACITY_DEF,
  parameter int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  krt_in_if.sink          in_item,
  krt_out_if.source       out_item,
  output logic            mem_we,
  output logic [IW-1:0]   mem_waddr,
  output krt_pkg::rec_t   mem_wdata,
  output logic [IW-1:0]   mem_raddr,
  input  krt_pkg::rec_t   mem_rdata
);
  import krt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + 1;
  localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_CMP     = 3'd2;
  localparam logic [2:0] S_INS     = 3'd3;
  localparam logic [2:0] S_SHIFT   = 3'd4;
  localparam logic [2:0] S_LIST_RD = 3'd5;
  localparam logic [2:0] S_LIST_EM = 3'd6;
  localparam logic [2:0] S_RESP    = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [QTY_W-1:0]   qty_r, qty_nxt;
  logic [PRICE_W-1:0] price_r, price_nxt;
  logic [ST_W-1:0]    st_r, st_nxt;
  rec_t               rec_r, rec_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]    out_st_r, out_st_nxt;
  rec_t               out_rec_r, out_rec_nxt;
  logic [CW-1:0]      out_cnt_r, out_cnt_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_ld;

  logic               can_emit;
  logic               key_hit;
  logic [XW-1:0]      idx1, idx2, cnt_x;
  rec_t               new_rec;

  assign can_emit = !out_valid_r || out_item.ready;
  assign key_hit  = (mem_rdata.key == $signed(key_r));
  assign idx1     = XW'(idx_r) + XW'(1);
  assign idx2     = XW'(idx_r) + XW'(2);
  assign cnt_x    = XW'(cnt_r);

  always_comb begin
    new_rec.key   = $signed(key_r);
    new_rec.qty   = qty_r;
    new_rec.price = price_r;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    qty_nxt   = qty_r;
    price_nxt = price_r;
    st_nxt    = st_r;
    rec_nxt   = rec_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = mem_rdata;
    mem_raddr = idx_r;
    out_ld       = 1'b0;
    out_st_nxt   = out_st_r;
    out_rec_nxt  = out_rec_r;
    out_cnt_nxt  = out_cnt_r;
    out_last_nxt = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_item.valid) begin
          op_nxt    = in_item.operation;
          key_nxt   = in_item.item_key;
          qty_nxt   = in_item.quantity_in;
          price_nxt = in_item.price_in;
          idx_nxt   = '0;
          rec_nxt   = '0;
          unique case (in_item.operation) inside
            OP_INSERT: begin
              if (cnt_x >= CAP_X) begin
                st_nxt    = ST_FULL;
                state_nxt = S_RESP;
              end else if (cnt_r == '0) begin
                state_nxt = S_INS;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_DELETE, OP_SEARCH, OP_SET_QTY, OP_SET_PRICE, OP_LIST: begin
              if (cnt_r == '0) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_RESP;
              end else if (in_item.operation == OP_LIST) begin
                state_nxt = S_LIST_RD;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              st_nxt    = ST_INVALID;
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        mem_raddr = idx_r;
        state_nxt = S_CMP;
      end

      S_CMP: begin
        // read of the following slot goes out every cycle here
        mem_raddr = idx1[IW-1:0];
        if (key_hit) begin
          st_nxt    = ST_OK;
          state_nxt = S_RESP;
          rec_nxt   = mem_rdata;
          unique case (op_r)
            OP_INSERT: begin
              st_nxt  = ST_DUP;
              rec_nxt = '0;
            end
            OP_DELETE: begin
              if (idx1 == cnt_x) begin
                cnt_nxt = cnt_r - CW'(1);
              end else begin
                state_nxt = S_SHIFT;
              end
            end
            OP_SET_QTY: begin
              rec_nxt.qty = qty_r;
              mem_we      = 1'b1;
              mem_wdata   = {mem_rdata.key, qty_r, mem_rdata.price};
            end
            OP_SET_PRICE: begin
              rec_nxt.price = price_r;
              mem_we        = 1'b1;
              mem_wdata     = {mem_rdata.key, mem_rdata.qty, price_r};
            end
            default: begin
            end
          endcase
        end else if (idx1 < cnt_x) begin
          idx_nxt = idx1[IW-1:0];
        end else if (op_r == OP_INSERT) begin
          state_nxt = S_INS;
        end else begin
          st_nxt    = ST_NOTFOUND;
          rec_nxt   = '0;
          state_nxt = S_RESP;
        end
      end

      S_INS: begin
        state_nxt = S_RESP;
        if (qty_r == '0 || price_r == '0) begin
          st_nxt  = ST_INVALID;
          rec_nxt = '0;
        end else begin
          st_nxt    = ST_OK;
          rec_nxt   = new_rec;
          mem_we    = 1'b1;
          mem_waddr = cnt_r[IW-1:0];
          mem_wdata = new_rec;
          cnt_nxt   = cnt_r + CW'(1);
        end
      end

      S_SHIFT: begin
        // read data is the slot above idx, moved down one
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        mem_raddr = idx2[IW-1:0];
        if (idx2 == cnt_x) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_RESP;
        end else begin
          idx_nxt = idx1[IW-1:0];
        end
      end

      S_LIST_RD: begin
        mem_raddr = idx_r;
        state_nxt = S_LIST_EM;
      end

      S_LIST_EM: begin
        if (can_emit) begin
          out_ld       = 1'b1;
          out_st_nxt   = ST_OK;
          out_rec_nxt  = mem_rdata;
          out_cnt_nxt  = cnt_r;
          out_last_nxt = (idx1 == cnt_x);
          mem_raddr    = idx1[IW-1:0];
          if (idx1 == cnt_x) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx1[IW-1:0];
          end
        end else begin
          // hold the read data while the output is stalled
          mem_raddr = idx_r;
        end
      end

      S_RESP: begin
        if (can_emit) begin
          out_ld       = 1'b1;
          out_st_nxt   = st_r;
          out_rec_nxt  = rec_r;
          out_cnt_nxt  = cnt_r;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_item.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    qty_r      <= qty_nxt;
    price_r    <= price_nxt;
    st_r       <= st_nxt;
    rec_r      <= rec_nxt;
    out_st_r   <= out_st_nxt;
    out_rec_r  <= out_rec_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_item.ready         = (state_r == S_IDLE);
  assign out_item.valid        = out_valid_r;
  assign out_item.status       = out_st_r;
  assign out_item.key_out      = out_rec_r.key;
  assign out_item.quantity_out = out_rec_r.qty;
  assign out_item.price_out    = out_rec_r.price;
  assign out_item.entry_count  = CNT_W'(out_cnt_r);
  assign out_item.last         = out_last_r;

endmodule
